/* hdl/coupled_inductor_euler_step_macros.svh */
// ============================================================================
// Coupled inductor Euler step - assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ============================================================================
`ifndef COUPLED_INDUCTOR_EULER_STEP_MACROS_SVH
`define COUPLED_INDUCTOR_EULER_STEP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is asserted
`define CIES_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CIES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CIES_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define CIES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hdl/cies_pkg.sv */
// ============================================================================
// Coupled inductor Euler step - shared package
// Field widths, register indexes and interface types of the block.
// ============================================================================
package cies_pkg;

    // windings and gain registers
    localparam int NUM_WIND  = 3;
    localparam int NUM_GAINS = 6;

    // fixed point widths
    localparam int VOLT_W     = 24;            // Q16.8
    localparam int DIFF_W     = VOLT_W + 1;    // Q17.8
    localparam int GAIN_W     = 32;            // Q2.30
    localparam int PROD_W     = DIFF_W + GAIN_W;
    localparam int ROW_W      = PROD_W + 2;    // three products, exact
    localparam int FRAC_SHIFT = 14;            // Q21.38 -> Q21.24
    localparam int INC_W      = ROW_W - FRAC_SHIFT;
    localparam int OUT_W      = 48;            // Q24.24

    // configuration port
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        GAIN_11 = 3'd0,
        GAIN_12 = 3'd1,
        GAIN_13 = 3'd2,
        GAIN_22 = 3'd3,
        GAIN_23 = 3'd4,
        GAIN_33 = 3'd5
    } t_gain_idx;

    typedef logic signed [VOLT_W-1:0] t_volt;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [GAIN_W-1:0] t_gain;
    typedef logic signed [INC_W-1:0]  t_inc;
    typedef logic signed [OUT_W-1:0]  t_current;

    // upper triangle of the symmetric gain matrix
    typedef struct packed {
        t_gain g11;
        t_gain g12;
        t_gain g13;
        t_gain g22;
        t_gain g23;
        t_gain g33;
    } t_gain_mat;

    // pipeline load enables
    typedef struct packed {
        logic load_prod;
        logic load_inc;
        logic acc_upd;
    } t_stage_ctl;

endpackage

/* hdl/cies_gain_regs.sv */
// ============================================================================
// Coupled inductor Euler step - gain register file
// Six software-written Q2.30 entries of the symmetric gain matrix.
// ============================================================================
module cies_gain_regs
    import cies_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    output t_gain_mat            o_gains
);

    t_gain_mat r_gains;
    t_gain_mat n_gains;

    // index decode, unused indexes are dropped
    always_comb begin
        n_gains = r_gains;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                GAIN_11: n_gains.g11 = i_cfg_data;
                GAIN_12: n_gains.g12 = i_cfg_data;
                GAIN_13: n_gains.g13 = i_cfg_data;
                GAIN_22: n_gains.g22 = i_cfg_data;
                GAIN_23: n_gains.g23 = i_cfg_data;
                GAIN_33: n_gains.g33 = i_cfg_data;
                default: n_gains = r_gains;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
        end else begin
            r_gains <= n_gains;
        end
    end

    assign o_gains = r_gains;

endmodule

/* hdl/cies_mac.sv */
// ============================================================================
// Coupled inductor Euler step - matrix multiply and rounding
// Nine parallel products, then row sums rounded to Q21.24 increments.
// ============================================================================
module cies_mac
    import cies_pkg::*;
(
    input  logic       i_clk,
    input  t_stage_ctl i_ctl,
    input  t_diff      i_diff [NUM_WIND],
    input  t_gain_mat  i_gains,
    output t_inc       o_inc  [NUM_WIND]
);

    localparam logic signed [ROW_W-1:0] ROUND_BIAS = ROW_W'(2 ** (FRAC_SHIFT - 1));

    t_gain                    gain_mat [NUM_WIND][NUM_WIND];
    logic signed [PROD_W-1:0] r_prod   [NUM_WIND][NUM_WIND];
    logic signed [ROW_W-1:0]  row_sum  [NUM_WIND];
    t_inc                     r_inc    [NUM_WIND];

    // full matrix from the upper triangle
    always_comb begin
        gain_mat[0][0] = i_gains.g11;
        gain_mat[0][1] = i_gains.g12;
        gain_mat[0][2] = i_gains.g13;
        gain_mat[1][0] = i_gains.g12;
        gain_mat[1][1] = i_gains.g22;
        gain_mat[1][2] = i_gains.g23;
        gain_mat[2][0] = i_gains.g13;
        gain_mat[2][1] = i_gains.g23;
        gain_mat[2][2] = i_gains.g33;
    end

    // product stage: one multiplier per matrix entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_prod) begin
            for (int r = 0; r < NUM_WIND; r++) begin
                for (int c = 0; c < NUM_WIND; c++) begin
                    r_prod[r][c] <= i_diff[c] * gain_mat[r][c];
                end
            end
        end
    end

    // exact row sums plus half an LSB, floor shift down to Q21.24
    always_comb begin
        for (int r = 0; r < NUM_WIND; r++) begin
            row_sum[r] = ROW_W'(r_prod[r][0]) + ROW_W'(r_prod[r][1])
                       + ROW_W'(r_prod[r][2]) + ROUND_BIAS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_inc) begin
            for (int r = 0; r < NUM_WIND; r++) begin
                r_inc[r] <= $signed(row_sum[r][ROW_W-1:FRAC_SHIFT]);
            end
        end
    end

    assign o_inc = r_inc;

endmodule

/* hdl/cies_accum.sv */
// ============================================================================
// Coupled inductor Euler step - current accumulators
// Saturating winding current accumulators and the output register.
// ============================================================================
module cies_accum
    import cies_pkg::*;
#(
    parameter int ACC_WIDTH = 48
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_stage_ctl i_ctl,
    input  t_inc       i_inc     [NUM_WIND],
    output t_current   o_current [NUM_WIND]
);

    localparam int SUM_W = ((ACC_WIDTH > INC_W) ? ACC_WIDTH : INC_W) + 1;
    localparam int EXT_W = (ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W;

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic signed [OUT_W-1:0]     OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0]     OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    logic signed [ACC_WIDTH-1:0]  r_acc  [NUM_WIND];
    logic signed [ACC_WIDTH-1:0]  n_acc  [NUM_WIND];
    logic signed [SUM_W-1:0]      acc_sum[NUM_WIND];
    logic [SUM_W-ACC_WIDTH:0]     sum_top[NUM_WIND];
    logic signed [EXT_W-1:0]      acc_ext[NUM_WIND];
    logic [EXT_W-OUT_W:0]         ext_top[NUM_WIND];
    t_current                     r_out  [NUM_WIND];
    t_current                     n_out  [NUM_WIND];

    // saturating add, then clamp to the output range
    always_comb begin
        for (int w = 0; w < NUM_WIND; w++) begin
            acc_sum[w] = SUM_W'(r_acc[w]) + SUM_W'(i_inc[w]);
            sum_top[w] = acc_sum[w][SUM_W-1:ACC_WIDTH-1];
            if ((&sum_top[w]) || !(|sum_top[w])) begin
                n_acc[w] = acc_sum[w][ACC_WIDTH-1:0];
            end else if (acc_sum[w][SUM_W-1]) begin
                n_acc[w] = ACC_MIN;
            end else begin
                n_acc[w] = ACC_MAX;
            end

            acc_ext[w] = EXT_W'(n_acc[w]);
            ext_top[w] = acc_ext[w][EXT_W-1:OUT_W-1];
            if ((&ext_top[w]) || !(|ext_top[w])) begin
                n_out[w] = acc_ext[w][OUT_W-1:0];
            end else if (acc_ext[w][EXT_W-1]) begin
                n_out[w] = OUT_MIN;
            end else begin
                n_out[w] = OUT_MAX;
            end
        end
    end

    // accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < NUM_WIND; w++) begin
                r_acc[w] <= '0;
            end
        end else if (i_ctl.acc_upd) begin
            r_acc <= n_acc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_upd) begin
            r_out <= n_out;
        end
    end

    assign o_current = r_out;

endmodule

/* hdl/coupled_inductor_euler_step.sv */
// ============================================================================
// Coupled inductor Euler step - top level
// Three-winding coupled inductor, one forward Euler time step per item.
//
//   channel  direction  handshake                 payload
//   input    in         i_valid / o_stall         six node voltages, Q16.8
//   result   out        o_valid / i_stall         three currents, Q24.24
//   config   in         i_cfg_valid / o_cfg_ready register index, 32-bit gain
//
// One transaction per cycle in both directions while neither side stalls;
// a result appears four register stages after its input (voltage difference,
// products, rounded increments, accumulators). The saturating accumulator add
// closes the only feedback loop. Reset is synchronous and clears gains, current
// accumulators and stage valids. A stall at the result side fills the four
// stages before the input side is stalled.
// ============================================================================
`include "coupled_inductor_euler_step_macros.svh"

module coupled_inductor_euler_step
    import cies_pkg::*;
#(
    parameter int ACC_WIDTH = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [VOLT_W-1:0]    i_pos_volt_a,
    input  logic [VOLT_W-1:0]    i_neg_volt_a,
    input  logic [VOLT_W-1:0]    i_pos_volt_b,
    input  logic [VOLT_W-1:0]    i_neg_volt_b,
    input  logic [VOLT_W-1:0]    i_pos_volt_c,
    input  logic [VOLT_W-1:0]    i_neg_volt_c,
    // results
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [OUT_W-1:0]     o_current_a,
    output logic [OUT_W-1:0]     o_current_b,
    output logic [OUT_W-1:0]     o_current_c,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data
);

    logic       r_v_in;
    logic       r_v_prod;
    logic       r_v_inc;
    logic       r_v_out;
    logic       in_free;
    logic       prod_free;
    logic       inc_free;
    logic       out_free;
    t_stage_ctl stage_ctl;
    t_gain_mat  gains;
    t_diff      r_diff   [NUM_WIND];
    t_diff      n_diff   [NUM_WIND];
    t_inc       inc      [NUM_WIND];
    t_current   currents [NUM_WIND];

    // stage advance chain, each stage moves when the next one is free
    assign out_free  = !r_v_out || !i_stall;
    assign inc_free  = !r_v_inc || out_free;
    assign prod_free = !r_v_prod || inc_free;
    assign in_free   = !r_v_in || prod_free;

    assign stage_ctl.load_prod = prod_free;
    assign stage_ctl.load_inc  = inc_free;
    assign stage_ctl.acc_upd   = r_v_inc && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in   <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_inc  <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            if (in_free)   r_v_in   <= i_valid;
            if (prod_free) r_v_prod <= r_v_in;
            if (inc_free)  r_v_inc  <= r_v_prod;
            if (out_free)  r_v_out  <= r_v_inc;
        end
    end

    // winding voltages, exact in Q17.8
    always_comb begin
        n_diff[0] = DIFF_W'($signed(i_pos_volt_a)) - DIFF_W'($signed(i_neg_volt_a));
        n_diff[1] = DIFF_W'($signed(i_pos_volt_b)) - DIFF_W'($signed(i_neg_volt_b));
        n_diff[2] = DIFF_W'($signed(i_pos_volt_c)) - DIFF_W'($signed(i_neg_volt_c));
    end

    always_ff @(posedge i_clk) begin
        if (in_free) begin
            r_diff <= n_diff;
        end
    end

    cies_gain_regs u_gain_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_gains     (gains)
    );

    cies_mac u_mac (
        .i_clk   (i_clk),
        .i_ctl   (stage_ctl),
        .i_diff  (r_diff),
        .i_gains (gains),
        .o_inc   (inc)
    );

    cies_accum #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (stage_ctl),
        .i_inc     (inc),
        .o_current (currents)
    );

    // ports
    assign o_stall     = !in_free;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_v_out;
    assign o_current_a = currents[0];
    assign o_current_b = currents[1];
    assign o_current_c = currents[2];

    // input is only held off when every stage is full and the result waits
    `CIES_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_stall,
        r_v_in && r_v_prod && r_v_inc && r_v_out && i_stall,
        "input stalled while the pipeline has room")

    // an accepted transaction lands in the input stage
    `CIES_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, i_valid && !o_stall, r_v_in,
        "accepted transaction not captured")

    // a blocked increment stays until the accumulators take it
    `CIES_ASSERT_NEXT(a_inc_held, i_clk, i_rst_n, r_v_inc && !out_free, r_v_inc,
        "increment dropped while result stalled")

    // a blocked product stage keeps its item and the stage after it full
    `CIES_ASSERT_NEXT(a_prod_held, i_clk, i_rst_n, r_v_prod && !inc_free,
        r_v_prod && r_v_inc, "product dropped while pipeline stalled")

endmodule

/* bench/tb_top.sv */
// ============================================================================
// Coupled inductor Euler step - testbench
// Streams node voltage transactions through the block and checks every
// current transaction against a cycle-free predictor of the fixed-point
// update: winding differences, symmetric gain matrix, round to Q24.24 and
// saturating accumulation. Gains are reloaded between phases once the
// block is drained, and each random phase sets its own source idle and
// sink stall rates.
// ============================================================================
module tb_top;
    import cies_pkg::*;

    localparam int ACC_W           = 48;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int DRAIN_CYCLES    = 16;
    localparam int REPORT_CAP      = 200;

    // spare register indexes that the block must ignore
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = CFG_IDX_W'(NUM_GAINS);
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = '1;

    localparam t_volt VMAX = 24'h7FFFFF;
    localparam t_volt VMIN = 24'h800000;
    localparam t_gain GMAX = 32'h7FFFFFFF;
    localparam t_gain GMIN = 32'h80000000;

    typedef enum int {GSET_UNIT, GSET_MAX, GSET_MIN, GSET_MIXED, GSET_RANDOM, GSET_LOW}
        t_gain_set;
    typedef enum int {BURST_NOISE, BURST_CORNER, BURST_RAMP, BURST_QUIET} t_burst;

    typedef struct packed {
        t_volt pos_a;
        t_volt neg_a;
        t_volt pos_b;
        t_volt neg_b;
        t_volt pos_c;
        t_volt neg_c;
    } t_node_volts;

    typedef struct packed {
        t_current cur_a;
        t_current cur_b;
        t_current cur_c;
    } t_winding_currents;

    // DUT signals
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [VOLT_W-1:0]    i_pos_volt_a = '0;
    logic [VOLT_W-1:0]    i_neg_volt_a = '0;
    logic [VOLT_W-1:0]    i_pos_volt_b = '0;
    logic [VOLT_W-1:0]    i_neg_volt_b = '0;
    logic [VOLT_W-1:0]    i_pos_volt_c = '0;
    logic [VOLT_W-1:0]    i_neg_volt_c = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [OUT_W-1:0]     o_current_a;
    logic [OUT_W-1:0]     o_current_b;
    logic [OUT_W-1:0]     o_current_c;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [GAIN_W-1:0]    i_cfg_data = '0;

    // predictor state
    t_gain  gain_mat [NUM_WIND][NUM_WIND];
    longint winding_acc [NUM_WIND];

    // traffic
    t_node_volts       pending_volts[$];
    t_node_volts       held_volts;
    t_winding_currents expected_currents[$];
    int                idle_pct = 0;
    int                stall_pct = 0;
    int                mismatches = 0;
    int                cycle_count = 0;

    coupled_inductor_euler_step #(.ACC_WIDTH(ACC_W)) dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        for (int r = 0; r < NUM_WIND; r++) begin
            winding_acc[r] = 0;
            for (int c = 0; c < NUM_WIND; c++)
                gain_mat[r][c] = '0;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint clamp_to(longint x, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    function automatic void set_gain(t_gain_idx idx, t_gain val);
        case (idx)
            GAIN_11: gain_mat[0][0] = val;
            GAIN_12: begin
                gain_mat[0][1] = val;
                gain_mat[1][0] = val;
            end
            GAIN_13: begin
                gain_mat[0][2] = val;
                gain_mat[2][0] = val;
            end
            GAIN_22: gain_mat[1][1] = val;
            GAIN_23: begin
                gain_mat[1][2] = val;
                gain_mat[2][1] = val;
            end
            GAIN_33: gain_mat[2][2] = val;
            default: ;
        endcase
    endfunction

    // one Euler step: updates the winding accumulators, returns emitted currents
    function automatic t_winding_currents step_currents(t_node_volts v);
        longint diff [NUM_WIND];
        longint emit [NUM_WIND];
        longint row_sum;
        longint incr;
        t_winding_currents res;
        diff[0] = longint'($signed(v.pos_a)) - longint'($signed(v.neg_a));
        diff[1] = longint'($signed(v.pos_b)) - longint'($signed(v.neg_b));
        diff[2] = longint'($signed(v.pos_c)) - longint'($signed(v.neg_c));
        for (int r = 0; r < NUM_WIND; r++) begin
            row_sum = 0;
            for (int c = 0; c < NUM_WIND; c++)
                row_sum += longint'(gain_mat[r][c]) * diff[c];
            // round half up: add half an LSB, floor shift
            incr = (row_sum + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
            winding_acc[r] = clamp_to(winding_acc[r] + incr, ACC_W);
            emit[r] = clamp_to(winding_acc[r], OUT_W);
        end
        res.cur_a = t_current'(emit[0]);
        res.cur_b = t_current'(emit[1]);
        res.cur_c = t_current'(emit[2]);
        return res;
    endfunction

    // append one voltage transaction to the send queue
    function automatic void add_pending(t_node_volts v);
        pending_volts = {pending_volts, v};
    endfunction

    // ------------------------------------------------------------------------
    // Driver: launches queued voltage transactions, predicts on acceptance
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid)
                expected_currents = {expected_currents, step_currents(held_volts)};
            if (pending_volts.size() != 0 && $urandom_range(99) >= idle_pct) begin
                held_volts = pending_volts.pop_front();
                i_valid      <= 1'b1;
                i_pos_volt_a <= held_volts.pos_a;
                i_neg_volt_a <= held_volts.neg_a;
                i_pos_volt_b <= held_volts.pos_b;
                i_neg_volt_b <= held_volts.neg_b;
                i_pos_volt_c <= held_volts.pos_c;
                i_neg_volt_c <= held_volts.neg_c;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compares current transactions, drives sink stall
    // ------------------------------------------------------------------------
    task automatic check_current(string label, t_current want, logic [OUT_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t %s mismatch: expected %0d, got %0d",
                         $time, label, want, $signed(got));
        end
    endtask

    always @(posedge i_clk) begin
        t_winding_currents want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_currents.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected result: expected none, got %0d %0d %0d",
                             $time, $signed(o_current_a), $signed(o_current_b),
                             $signed(o_current_c));
                end else begin
                    want = expected_currents.pop_front();
                    check_current("current_a", want.cur_a, o_current_a);
                    check_current("current_b", want.cur_b, o_current_b);
                    check_current("current_c", want.cur_c, o_current_c);
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // called at a clock edge; leaves i_cfg_valid high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_gain val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < NUM_GAINS)
            set_gain(t_gain_idx'(idx), val);
    endtask

    function automatic t_gain pick_gain(t_gain_set kind);
        case (kind)
            GSET_UNIT:   return t_gain'(1);
            GSET_MAX:    return GMAX;
            GSET_MIN:    return GMIN;
            GSET_RANDOM: return t_gain'($urandom);
            GSET_LOW:    return t_gain'(int'($urandom_range(2097152)) - 1048576);
            default: begin
                case ($urandom_range(4))
                    0:       return GMAX;
                    1:       return GMIN;
                    2:       return t_gain'(1);
                    3:       return t_gain'(-1);
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    // all six gains, plus writes to the unused indexes
    task automatic load_gains(t_gain_set kind);
        for (int k = 0; k < NUM_GAINS; k++)
            write_reg(k[CFG_IDX_W-1:0], pick_gain(kind));
        write_reg(IDX_SPARE_LO, t_gain'($urandom));
        write_reg(IDX_SPARE_HI, t_gain'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_volts.size() != 0 || i_valid || expected_currents.size() != 0);
    endtask

    function automatic t_volt pick_volt(t_burst kind, bit hi);
        case (kind)
            BURST_RAMP:
                return hi ? VMAX - t_volt'($urandom_range(255))
                          : VMIN + t_volt'($urandom_range(255));
            BURST_QUIET:
                return t_volt'(int'($urandom_range(1024)) - 512);
            BURST_CORNER: begin
                case ($urandom_range(4))
                    0:       return VMAX;
                    1:       return VMIN;
                    2:       return t_volt'(1);
                    3:       return t_volt'(-1);
                    default: return '0;
                endcase
            end
            default: return t_volt'($urandom);
        endcase
    endfunction

    // ramps keep each winding's polarity for the whole burst to drive
    // the accumulators into saturation
    task automatic queue_burst(t_burst kind, int len);
        bit [2:0] dir;
        t_node_volts v;
        dir = 3'($urandom);
        repeat (len) begin
            v.pos_a = pick_volt(kind, dir[0]);
            v.neg_a = pick_volt(kind, !dir[0]);
            v.pos_b = pick_volt(kind, dir[1]);
            v.neg_b = pick_volt(kind, !dir[1]);
            v.pos_c = pick_volt(kind, dir[2]);
            v.neg_c = pick_volt(kind, !dir[2]);
            add_pending(v);
        end
    endtask

    task automatic queue_corners();
        add_pending('{VMAX, VMIN, VMAX, VMIN, VMAX, VMIN});
        add_pending('{VMIN, VMAX, VMIN, VMAX, VMIN, VMAX});
        add_pending('{VMAX, VMAX, VMIN, VMIN, '0, '0});
        add_pending('{VMAX, VMIN, VMIN, VMAX, VMAX, VMIN});
        add_pending('{t_volt'(-1), '0, '0, t_volt'(-1), t_volt'(1), '0});
        add_pending('{'0, '0, '0, '0, '0, '0});
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        t_gain_set gset;
        int        left;
        int        len;
        int        pick;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // gains at reset value: currents must stay zero
        add_pending('{VMAX, VMIN, VMIN, VMAX, VMAX, VMIN});
        add_pending('{VMIN, VMAX, VMAX, VMIN, VMIN, VMAX});
        wait_drained();

        // unit gains: rounding ties go toward plus infinity
        load_gains(GSET_UNIT);
        add_pending('{t_volt'(8192), '0, '0, '0, '0, '0});
        add_pending('{'0, t_volt'(8192), '0, '0, '0, '0});
        add_pending('{'0, '0, t_volt'(24576), '0, '0, '0});
        add_pending('{'0, '0, '0, t_volt'(24576), '0, '0});
        add_pending('{'0, '0, '0, '0, t_volt'(8191), '0});
        add_pending('{'0, '0, '0, '0, '0, t_volt'(8193)});
        wait_drained();

        // extreme gains with extreme voltages
        load_gains(GSET_MAX);
        queue_corners();
        wait_drained();
        load_gains(GSET_MIN);
        queue_corners();
        wait_drained();

        // random phases, each with its own gains and flow control
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            case (ph % 6)
                0: gset = GSET_RANDOM;
                1: gset = GSET_MIXED;
                2: gset = GSET_LOW;
                3: gset = GSET_MAX;
                4: gset = GSET_MIN;
                default: gset = GSET_RANDOM;
            endcase
            load_gains(gset);
            left = ITEMS_PER_PHASE;
            while (left > 0) begin
                len  = $urandom_range(30, 1);
                if (len > left) len = left;
                pick = $urandom_range(99);
                if (pick < 35)      queue_burst(BURST_RAMP, len);
                else if (pick < 65) queue_burst(BURST_NOISE, len);
                else if (pick < 85) queue_burst(BURST_CORNER, len);
                else                queue_burst(BURST_QUIET, len);
                left -= len;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/cies_pkg.sv
hdl/cies_gain_regs.sv
hdl/cies_mac.sv
hdl/cies_accum.sv
hdl/coupled_inductor_euler_step.sv
bench/tb_top.sv
